// ===== rtl/scheduling_request_control_top_macros.svh =====
// Assertion macros shared by the checker of the scheduling request engine.
// No dependencies; expects signals named clk and rst_n in the using scope.
`ifndef SCHEDULING_REQUEST_CONTROL_TOP_MACROS_SVH
`define SCHEDULING_REQUEST_CONTROL_TOP_MACROS_SVH

// Checked only while the engine is out of reset.
`define SRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/srctl_pkg.sv =====
// Shared constants, codes and types of the scheduling request engine.
// No dependencies; used by the modulo unit and the top level.
package srctl_pkg;

  // Time stamps are kept modulo 2^TIME_BITS (legal range 16 to 64).
  localparam int TIME_BITS  = 32;
  localparam int PROHIBIT_W = 20;
  localparam int CMP_W      = (TIME_BITS > PROHIBIT_W) ? TIME_BITS : PROHIBIT_W;

  // Serial modulo unit: 32-bit dividend, divisor below 1024.
  localparam int MOD_W  = 32;
  localparam int DIV_W  = 10;
  localparam int CNT_W  = $clog2(MOD_W);

  // Frame number times frame size, and the occasion test argument.
  localparam int PROD_W = 19;
  localparam int OCC_W  = 22;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SR_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROHIBIT_US    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TX         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SLOTS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SLOTS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_FRAME = 3'd5;

  // Request kinds.
  localparam logic [1:0] ACT_GENERATE = 2'd0;
  localparam logic [1:0] ACT_TICK     = 2'd1;
  localparam logic [1:0] ACT_GRANT    = 2'd2;

  // Counter values.
  localparam logic signed [7:0] TX_IDLE = -8'sd1;
  localparam logic signed [7:0] TX_SAT  = 8'sd127;
  localparam logic [7:0]        PEND_SAT = 8'd255;

  // Request to and response from the shared modulo unit.
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } mod_rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SLOT_MOD = 4'b0010,
    ST_OCC_MOD  = 4'b0100,
    ST_FINISH   = 4'b1000
  } seq_state_t;

endpackage

// ===== rtl/srctl_mod.sv =====
// Serial restoring modulo unit: one dividend bit per cycle.
// Depends on srctl_pkg for widths and the request and response types.
module srctl_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  srctl_pkg::mod_req_t req,
  output srctl_pkg::mod_rsp_t rsp
);
  import srctl_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W:0]   trial;
  logic             trial_ge;

  // One shift and conditional subtract of the partial remainder.
  assign trial    = {rem_r, dvd_r[MOD_W-1]};
  assign trial_ge = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[MOD_W-2:0], 1'b0};
      rem_nxt = trial_ge ? DIV_W'(trial - {1'b0, dsr_r}) : trial[DIV_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(MOD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/scheduling_request_control_top.sv =====
// Top level of the scheduling request engine: sequencer, engine state, output register.
// Depends on srctl_pkg and the serial modulo unit srctl_mod.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  in_      | input     | in_valid/in_stall  | action, schedule flag, frame, slot, time
//  out_     | output    | out_valid/out_stall| sent flag, slot stamp, grant, pending, count
//  cfg_     | input     | cfg_we             | register index and write data
//
// A slot tick with a request pending, no scheduled uplink and the engine enabled makes two passes
// through the serial modulo unit (slot within the frame, then the occasion test against the
// period): the second pass starts when the first is done, then the occasion is latched and the
// result is registered. Every other request goes from acceptance straight to the finish step.
// Reset is synchronous and active low and restores the register defaults. A stalled result
// holds the finish step, and no new request is taken meanwhile.
module scheduling_request_control_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port
  input  logic                                cfg_we,
  input  logic [srctl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srctl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic                                in_slot_scheduled,
  input  logic [9:0]                          in_frame_number,
  input  logic [31:0]                         in_slot_index,
  input  logic [31:0]                         in_now_us,
  input  logic                                in_grant_allowed,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_request_sent,
  output logic [31:0]                         out_request_slot,
  output logic                                out_grant_taken,
  output logic                                out_is_pending,
  output logic signed [7:0]                   out_tx_count
);
  import srctl_pkg::*;

  // Configuration registers.
  logic                  sr_enable_r;
  logic [PROHIBIT_W-1:0] prohibit_r;
  logic [6:0]            max_tx_r;
  logic [9:0]            period_r;
  logic [9:0]            offset_r;
  logic [8:0]            spf_r;

  // Engine state.
  logic [7:0]            pend_r, pend_nxt;
  logic signed [7:0]     tx_r, tx_nxt;
  logic [TIME_BITS-1:0]  last_tx_r, last_tx_nxt;

  // Sequencer and latched request.
  seq_state_t            state_r, state_nxt;
  logic [1:0]            act_r;
  logic                  sched_r;
  logic [31:0]           slot_r;
  logic [31:0]           now_r;
  logic                  allow_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  occ_r;

  // Output register.
  logic                  out_valid_r;
  logic                  sent_r;
  logic [31:0]           req_slot_r;
  logic                  taken_r;
  logic                  pending_r;
  logic signed [7:0]     tx_out_r;

  mod_req_t              mreq;
  mod_rsp_t              mrsp;

  logic                  accept;
  logic                  need_test;
  logic                  finish;
  logic [DIV_W-1:0]      s_eff;
  logic [DIV_W-1:0]      p_eff;
  logic [DIV_W-1:0]      r_term;
  logic [OCC_W-1:0]      occ_arg;
  logic [TIME_BITS-1:0]  now_tb;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  prohibit_over;
  logic                  sent;
  logic                  taken;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign finish   = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // A zero frame size or period counts as one.
  assign s_eff = (spf_r == 9'd0) ? DIV_W'(1) : DIV_W'(spf_r);
  assign p_eff = (period_r == 10'd0) ? DIV_W'(1) : DIV_W'(period_r);

  // Only a tick with a request pending and a free slot needs the occasion test.
  assign need_test = sr_enable_r && (in_action == ACT_TICK) && (pend_r != 8'd0) &&
                     !in_slot_scheduled;

  // Slot zero stands for the last slot of the previous frame, i.e. minus one.
  // Adding period times 1024 keeps the argument positive before the offset is removed.
  assign r_term  = (slot_r == 32'd0) ? (p_eff - DIV_W'(1)) : mrsp.rem;
  assign occ_arg = OCC_W'(prod_r) + OCC_W'(r_term) + (OCC_W'(p_eff) << DIV_W) -
                   OCC_W'(offset_r);

  // Requests to the shared modulo unit.
  always_comb begin
    mreq.start    = accept && need_test;
    mreq.dividend = MOD_W'(in_slot_index - 32'd1);
    mreq.divisor  = s_eff;
    if (state_r == ST_SLOT_MOD) begin
      mreq.start    = mrsp.done;
      mreq.dividend = MOD_W'(occ_arg);
      mreq.divisor  = p_eff;
    end
  end

  srctl_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = need_test ? ST_SLOT_MOD : ST_FINISH;
      end
      ST_SLOT_MOD: begin
        if (mrsp.done) state_nxt = ST_OCC_MOD;
      end
      ST_OCC_MOD: begin
        if (mrsp.done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Elapsed time since the last transmission, modulo the time width.
  assign now_tb        = TIME_BITS'(now_r);
  assign elapsed       = now_tb - last_tx_r;
  assign prohibit_over = CMP_W'(elapsed) >= CMP_W'(prohibit_r);

  // Engine update for the latched request.
  always_comb begin
    pend_nxt    = pend_r;
    tx_nxt      = tx_r;
    last_tx_nxt = last_tx_r;
    sent        = 1'b0;
    taken       = 1'b0;
    if (sr_enable_r) begin
      case (act_r)
        ACT_GENERATE: begin
          if (pend_r == 8'd0) tx_nxt = 8'sd0;
          if (pend_r != PEND_SAT) pend_nxt = pend_r + 8'd1;
        end
        ACT_TICK: begin
          if (pend_r != 8'd0) begin
            if (sched_r) begin
              pend_nxt = 8'd0;
              tx_nxt   = TX_IDLE;
            end else if (occ_r) begin
              if (tx_r == 8'sd0) begin
                sent = 1'b1;
              end else if (prohibit_over) begin
                if (tx_r < $signed({1'b0, max_tx_r})) begin
                  sent = 1'b1;
                end else begin
                  pend_nxt = 8'd0;
                  tx_nxt   = TX_IDLE;
                end
              end
            end
          end
          if (sent) begin
            if (tx_r < TX_SAT) tx_nxt = tx_r + 8'sd1;
            last_tx_nxt = now_tb;
          end
        end
        ACT_GRANT: begin
          if (allow_r) begin
            taken    = 1'b1;
            pend_nxt = 8'd0;
            tx_nxt   = TX_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state, configuration and engine state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sr_enable_r <= 1'b1;
      prohibit_r  <= '0;
      max_tx_r    <= 7'd4;
      period_r    <= 10'd10;
      offset_r    <= 10'd0;
      spf_r       <= 9'd10;
      pend_r      <= 8'd0;
      tx_r        <= TX_IDLE;
      last_tx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SR_ENABLE:       sr_enable_r <= cfg_wdata[0];
          REG_PROHIBIT_US:     prohibit_r  <= cfg_wdata[PROHIBIT_W-1:0];
          REG_MAX_TX:          max_tx_r    <= cfg_wdata[6:0];
          REG_PERIOD_SLOTS:    period_r    <= cfg_wdata[9:0];
          REG_OFFSET_SLOTS:    offset_r    <= cfg_wdata[9:0];
          REG_SLOTS_PER_FRAME: spf_r       <= cfg_wdata[8:0];
          default: begin
          end
        endcase
      end
      if (finish) begin
        pend_r      <= pend_nxt;
        tx_r        <= tx_nxt;
        last_tx_r   <= last_tx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latched request, occasion flag and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      sched_r <= in_slot_scheduled;
      slot_r  <= in_slot_index;
      now_r   <= in_now_us;
      allow_r <= in_grant_allowed;
      prod_r  <= PROD_W'(in_frame_number) * PROD_W'(s_eff);
      occ_r   <= 1'b0;
    end else if (state_r == ST_OCC_MOD && mrsp.done) begin
      occ_r <= (mrsp.rem == '0);
    end
    if (finish) begin
      sent_r     <= sent;
      req_slot_r <= sent ? slot_r : 32'd0;
      taken_r    <= taken;
      pending_r  <= (pend_nxt != 8'd0);
      tx_out_r   <= tx_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_request_sent = sent_r;
  assign out_request_slot = req_slot_r;
  assign out_grant_taken  = taken_r;
  assign out_is_pending   = pending_r;
  assign out_tx_count     = tx_out_r;

endmodule

// ===== rtl/srctl_checker.sv =====
// Port-level checker of the scheduling request engine, bound to the top level.
// Depends on scheduling_request_control_top_macros.svh for the assertion macros.
`include "scheduling_request_control_top_macros.svh"

module srctl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_request_sent,
  input logic [31:0]       out_request_slot,
  input logic              out_grant_taken,
  input logic              out_is_pending,
  input logic signed [7:0] out_tx_count
);

  // A held result keeps its valid, its request slot and its transmission count.
  `SRC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_request_slot) && $stable(out_tx_count), "stalled result changed")

  // Reset leaves no result on the output.
  `SRC_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "result valid after reset")

  // Once a request is taken the engine is busy in the next cycle.
  `SRC_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "accepted twice in a row")

  // An idle engine reports the idle counter, and a sent request keeps the engine pending.
  `SRC_ASSERT(a_idle_count, out_valid && !out_is_pending |-> out_tx_count == -8'sd1, "idle count wrong")

  // A transmission cannot coincide with a grant, and no stamp appears without one.
  `SRC_ASSERT(a_sent_consistent, out_valid |-> (out_request_sent ? (out_is_pending && !out_grant_taken) : (out_request_slot == 32'd0)), "inconsistent transmission report")

endmodule

bind scheduling_request_control_top srctl_checker u_srctl_checker (.*);
